// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define SLC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slc: next-cycle check failed");

// Consequent must hold in the same cycle as the antecedent.
`define SLC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slc: same-cycle check failed");

`endif

// ===== hw/rtl/slc_pkg.sv =====
// Shared constants, types and codes of the static link correlator.
package slc_pkg;

    localparam int MAX_EXTENT = 16;
    localparam int MAX_TIME   = 64;
    localparam int MAX_DIST   = 63;

    localparam int NCOMP = 3;
    localparam int NDIR  = 4;
    localparam int NLANE = NCOMP * NDIR;
    localparam int GRP   = 3;
    localparam int NGRP  = NLANE / GRP;

    localparam int EXT_W   = $clog2(MAX_EXTENT);
    localparam int EXT_CW  = $clog2(MAX_EXTENT + 1);
    localparam int WR_W    = EXT_W + 1;
    localparam int VOL_W   = 3 * EXT_W;
    localparam int TIME_CW = $clog2(MAX_TIME + 1);

    localparam int SIZE_W    = 5;
    localparam int TIME_W    = 7;
    localparam int DIST_W    = 6;
    localparam int DIR_W     = 2;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 3;

    localparam int COMP_W = 18;
    localparam int ACC_W  = 24;
    localparam int PSUM_W = ACC_W + 2;
    localparam int PROD_W = ACC_W + PSUM_W;
    localparam int SUM_W  = 64;
    localparam int VAL_W  = 36;
    localparam int DEN_W  = $clog2(3 * MAX_EXTENT * MAX_EXTENT * MAX_EXTENT
                                   * MAX_TIME * MAX_TIME + 1);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_T   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST = 3'd4;

    // Which neighbor a walk read fetches
    typedef enum logic [1:0] {
        PH_CENTER = 2'd0,
        PH_XN     = 2'd1,
        PH_YN     = 2'd2,
        PH_ZN     = 2'd3
    } phase_t;

    // Control shared by all lanes
    typedef struct packed {
        logic             clr_en;
        logic [VOL_W-1:0] clr_addr;
        logic [VOL_W-1:0] rd_addr;
        logic             cor_en;
        phase_t           cor_ph;
    } lane_ctl_t;

endpackage

// ===== hw/rtl/slc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module slc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/slc_lane.sv =====
// One lane: accumulator store of one component and direction, load and correlate.
module slc_lane (
    input  logic                              clk,
    input  logic                              rst_n,
    input  slc_pkg::lane_ctl_t                ctl,
    input  logic                              ld_en,
    input  logic signed [slc_pkg::COMP_W-1:0] comp,
    output logic                              prod_vld,
    output logic signed [slc_pkg::PROD_W-1:0] prod
);
    import slc_pkg::*;

    logic [ACC_W-1:0] rd_data;
    logic             we;
    logic [VOL_W-1:0] waddr;
    logic [ACC_W-1:0] wdata;

    logic               ld_pend_reg;
    logic [VOL_W-1:0]   ld_addr_reg;
    logic [COMP_W-1:0]  ld_val_reg;
    logic               tag_vld_reg;
    phase_t             tag_ph_reg;
    logic signed [ACC_W-1:0]  v_reg;
    logic signed [PSUM_W-1:0] p_reg;
    logic signed [ACC_W-1:0]  hv_reg;
    logic signed [PSUM_W-1:0] hp_reg;
    logic                     hold_vld_reg;
    logic                     prod_vld_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PSUM_W-1:0] data_ext;
    logic [ACC_W-1:0]         wsum;

    slc_ram #(.WIDTH(ACC_W), .DEPTH(1 << VOL_W)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (ctl.rd_addr),
        .rdata (rd_data)
    );

    // read-modify-write of a load, clearing sweep has priority
    assign wsum  = rd_data + {{(ACC_W - COMP_W){ld_val_reg[COMP_W-1]}}, ld_val_reg};
    assign we    = ctl.clr_en | ld_pend_reg;
    assign waddr = ctl.clr_en ? ctl.clr_addr : ld_addr_reg;
    assign wdata = ctl.clr_en ? '0 : wsum;

    assign data_ext = $signed({{(PSUM_W - ACC_W){rd_data[ACC_W-1]}}, rd_data});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ld_pend_reg  <= 1'b0;
            tag_vld_reg  <= 1'b0;
            hold_vld_reg <= 1'b0;
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            ld_pend_reg  <= ld_en;
            tag_vld_reg  <= ctl.cor_en;
            hold_vld_reg <= tag_vld_reg && (tag_ph_reg == PH_ZN);
            prod_vld_reg <= hold_vld_reg;
        end
    end

    // payload: load capture, neighbor sum, product
    always_ff @(posedge clk)
    begin
        ld_addr_reg <= ctl.rd_addr;
        ld_val_reg  <= comp;
        tag_ph_reg  <= ctl.cor_ph;
        if (tag_vld_reg)
        begin
            case (tag_ph_reg)
                PH_CENTER: v_reg <= $signed(rd_data);
                PH_XN:     p_reg <= data_ext;
                PH_YN:     p_reg <= p_reg + data_ext;
                default:
                begin
                    hv_reg <= v_reg;
                    hp_reg <= p_reg + data_ext;
                end
            endcase
        end
        prod_reg <= hv_reg * hp_reg;
    end

    assign prod_vld = prod_vld_reg;
    assign prod     = prod_reg;

endmodule

// ===== hw/rtl/slc_merge.sv =====
// Merge stage: adds the lane products into the running correlator sum.
module slc_merge (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_vld,
    input  logic                              sum_clr,
    input  logic signed [slc_pkg::PROD_W-1:0] prods [slc_pkg::NLANE],
    output logic [slc_pkg::SUM_W-1:0]         run_sum
);
    import slc_pkg::*;

    localparam int G_W = PROD_W + $clog2(GRP + 1);

    logic signed [G_W-1:0] grp_reg  [NGRP];
    logic signed [G_W-1:0] grp_next [NGRP];
    logic                  s1_vld_reg;
    logic [SUM_W-1:0]      run_sum_reg;
    logic [SUM_W-1:0]      total;

    // first level: groups of lanes
    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_next[g] = '0;
            for (int k = 0; k < GRP; k++)
            begin
                grp_next[g] = grp_next[g] + G_W'(prods[g * GRP + k]);
            end
        end
    end

    // second level: groups into one term
    always_comb
    begin
        total = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            total = total + SUM_W'(grp_reg[g]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_reg[g] <= grp_next[g];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            run_sum_reg <= '0;
        end
        else
        begin
            s1_vld_reg <= in_vld;
            if (sum_clr)
            begin
                run_sum_reg <= '0;
            end
            else if (s1_vld_reg)
            begin
                run_sum_reg <= run_sum_reg + total;
            end
        end
    end

    assign run_sum = run_sum_reg;

endmodule

// ===== hw/rtl/slc_div.sv =====
// Restoring divider, one quotient bit per cycle.
module slc_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [slc_pkg::SUM_W-1:0]   dividend,
    input  logic [slc_pkg::DEN_W-1:0]   divisor,
    output logic                        done,
    output logic [slc_pkg::SUM_W-1:0]   quotient
);
    import slc_pkg::*;

    localparam int CNT_W = $clog2(SUM_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [SUM_W-1:0] dvd_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W:0]   rem_sh;
    logic             fits;

    assign rem_sh = {rem_reg, dvd_reg[SUM_W-1]};
    assign fits   = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // shift dividend out, quotient bits in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            den_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[SUM_W-2:0], fits};
            rem_reg <= fits ? DEN_W'(rem_sh - {1'b0, den_reg}) : rem_sh[DEN_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

// ===== hw/rtl/static_link_correlator.sv =====
// Top level: load sequencer, lattice walk, lanes, merge, divide and result register.
// Load: each item is read, then written back in the lane RAMs; no new item is taken meanwhile.
// Compute: per distance r, a walk that reads each site and its x, y and z neighbors in turn
//   (one read port per lane RAM), then drain, divide and emit; after the last r, a store clear sweep.
// Reset: asynchronous active low; a clear sweep of the store follows reset, during which no
//   item is accepted (config writes are taken).
module static_link_correlator (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [slc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [slc_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              mode,
    input  logic [slc_pkg::EXT_W-1:0]         pos_x,
    input  logic [slc_pkg::EXT_W-1:0]         pos_y,
    input  logic [slc_pkg::EXT_W-1:0]         pos_z,
    input  logic [slc_pkg::DIR_W-1:0]         direction,
    input  logic signed [slc_pkg::COMP_W-1:0] comp_one,
    input  logic signed [slc_pkg::COMP_W-1:0] comp_two,
    input  logic signed [slc_pkg::COMP_W-1:0] comp_three,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [slc_pkg::DIST_W-1:0]        distance,
    output logic signed [slc_pkg::VAL_W-1:0]  value,
    output logic                              last
);
    import slc_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_WALK  = 6'b000100,
        S_DRAIN = 6'b001000,
        S_DIV   = 6'b010000,
        S_EMIT  = 6'b100000
    } state_t;

    localparam logic [2:0] DRAIN_LAST = 3'd6;
    localparam logic [SUM_W-1:0] LIM = SUM_W'(1) << (VAL_W - 1);

    state_t state_reg, state_next;

    logic [SIZE_W-1:0] size_x_reg, size_y_reg, size_z_reg;
    logic [TIME_W-1:0] size_t_reg;
    logic [DIST_W-1:0] max_dist_reg;

    logic [EXT_CW-1:0]  lx, ly, lz;
    logic [TIME_CW-1:0] lt;
    logic [DIST_W-1:0]  rmax;

    logic [EXT_CW-1:0]  lx_reg, ly_reg, lz_reg;
    logic [TIME_CW-1:0] lt_reg;
    logic [DEN_W-1:0]   d_xy_reg, d_xyz_reg, d_3_reg, d_tt_reg, den_reg;

    logic [DIST_W-1:0] r_reg, r_next;
    logic [EXT_W-1:0]  rx_reg, ry_reg, rz_reg, rx_next, ry_next, rz_next;
    logic [EXT_W-1:0]  x_reg, y_reg, z_reg, x_next, y_next, z_next;
    phase_t            ph_reg, ph_next;
    logic [2:0]        drain_reg, drain_next;
    logic [VOL_W-1:0]  clr_reg, clr_next;
    logic              ld_busy_reg;
    logic              neg_reg;

    logic              out_valid_reg;
    logic [DIST_W-1:0] dist_reg;
    logic [VAL_W-1:0]  value_reg;
    logic              last_reg;

    logic in_acc, ld_go, run_go, in_range, emit_load, sum_clr, div_start, div_done;
    logic x_end, y_end, z_end;
    logic [EXT_W-1:0] xr, yr, zr;
    logic [VOL_W-1:0] walk_addr;
    logic [SUM_W-1:0] run_sum, mag, quot, qsat;
    logic [VAL_W-1:0] val_bits;

    lane_ctl_t                ctl;
    logic signed [COMP_W-1:0] comps [NCOMP];
    logic [NLANE-1:0]         lane_vld;
    logic signed [PROD_W-1:0] prods [NLANE];

    // extent clamp: zero acts as 1, large values as the maximum
    function automatic logic [EXT_CW-1:0] clamp_ext(input logic [SIZE_W-1:0] v);
        logic [EXT_CW-1:0] res;
        if (v == '0)
        begin
            res = EXT_CW'(1);
        end
        else if (int'(v) > MAX_EXTENT)
        begin
            res = EXT_CW'(MAX_EXTENT);
        end
        else
        begin
            res = EXT_CW'(v);
        end
        return res;
    endfunction

    // wrap x + off into [0, len)
    function automatic logic [EXT_W-1:0] wrap_add(input logic [EXT_W-1:0] a,
                                                  input logic [EXT_W-1:0] off,
                                                  input logic [EXT_CW-1:0] len);
        logic [WR_W-1:0] s;
        s = {1'b0, a} + {1'b0, off};
        if (s >= WR_W'(len))
        begin
            s = s - WR_W'(len);
        end
        return s[EXT_W-1:0];
    endfunction

    // offset r mod len, stepped by one
    function automatic logic [EXT_W-1:0] step_off(input logic [EXT_W-1:0] off,
                                                  input logic [EXT_CW-1:0] len);
        logic [WR_W-1:0] s;
        s = {1'b0, off} + WR_W'(1);
        if (s == WR_W'(len))
        begin
            s = '0;
        end
        return s[EXT_W-1:0];
    endfunction

    assign lx = clamp_ext(size_x_reg);
    assign ly = clamp_ext(size_y_reg);
    assign lz = clamp_ext(size_z_reg);
    assign lt = (size_t_reg == '0) ? TIME_CW'(1) :
                (int'(size_t_reg) > MAX_TIME) ? TIME_CW'(MAX_TIME) : TIME_CW'(size_t_reg);
    assign rmax = (int'(max_dist_reg) > MAX_DIST) ? DIST_W'(MAX_DIST) : max_dist_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg   <= SIZE_W'(8);
            size_y_reg   <= SIZE_W'(8);
            size_z_reg   <= SIZE_W'(8);
            size_t_reg   <= TIME_W'(8);
            max_dist_reg <= DIST_W'(4);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SIZE_X:   size_x_reg   <= cfg_data[SIZE_W-1:0];
                CFG_SIZE_Y:   size_y_reg   <= cfg_data[SIZE_W-1:0];
                CFG_SIZE_Z:   size_z_reg   <= cfg_data[SIZE_W-1:0];
                CFG_SIZE_T:   size_t_reg   <= cfg_data[TIME_W-1:0];
                CFG_MAX_DIST: max_dist_reg <= cfg_data[DIST_W-1:0];
                default:      ;
            endcase
        end
    end

    // normalization 3*Vs*Lt^2, one multiply per stage, settles long before use
    always_ff @(posedge clk)
    begin
        lx_reg    <= lx;
        ly_reg    <= ly;
        lz_reg    <= lz;
        lt_reg    <= lt;
        d_xy_reg  <= DEN_W'(DEN_W'(lx_reg) * DEN_W'(ly_reg));
        d_xyz_reg <= DEN_W'(d_xy_reg * DEN_W'(lz_reg));
        d_3_reg   <= DEN_W'(d_xyz_reg * DEN_W'(3));
        d_tt_reg  <= DEN_W'(DEN_W'(lt_reg) * DEN_W'(lt_reg));
        den_reg   <= DEN_W'(d_3_reg * d_tt_reg);
    end

    // input handshake
    assign in_ready = (state_reg == S_IDLE) && !ld_busy_reg;
    assign in_acc   = in_valid && in_ready;
    assign in_range = ({1'b0, pos_x} < WR_W'(lx)) && ({1'b0, pos_y} < WR_W'(ly))
                   && ({1'b0, pos_z} < WR_W'(lz));
    assign ld_go    = in_acc && !mode && in_range;
    assign run_go   = in_acc && mode;

    // walk addressing
    assign xr = wrap_add(x_reg, rx_reg, lx);
    assign yr = wrap_add(y_reg, ry_reg, ly);
    assign zr = wrap_add(z_reg, rz_reg, lz);
    assign x_end = ({1'b0, x_reg} == WR_W'(lx) - WR_W'(1));
    assign y_end = ({1'b0, y_reg} == WR_W'(ly) - WR_W'(1));
    assign z_end = ({1'b0, z_reg} == WR_W'(lz) - WR_W'(1));

    always_comb
    begin
        case (ph_reg)
            PH_CENTER: walk_addr = {z_reg, y_reg, x_reg};
            PH_XN:     walk_addr = {z_reg, y_reg, xr};
            PH_YN:     walk_addr = {z_reg, yr, x_reg};
            default:   walk_addr = {zr, y_reg, x_reg};
        endcase
    end

    assign ctl.clr_en   = (state_reg == S_CLEAR);
    assign ctl.clr_addr = clr_reg;
    assign ctl.rd_addr  = (state_reg == S_WALK) ? walk_addr : {pos_z, pos_y, pos_x};
    assign ctl.cor_en   = (state_reg == S_WALK);
    assign ctl.cor_ph   = ph_reg;

    assign comps[0] = comp_one;
    assign comps[1] = comp_two;
    assign comps[2] = comp_three;

    // one lane per component and direction
    for (genvar l = 0; l < NLANE; l++)
    begin : g_lane
        localparam int A  = l / NDIR;
        localparam int MU = l % NDIR;
        slc_lane u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .ld_en    (ld_go && (direction == DIR_W'(MU))),
            .comp     (comps[A]),
            .prod_vld (lane_vld[l]),
            .prod     (prods[l])
        );
    end

    slc_merge u_merge (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (&lane_vld),
        .sum_clr (sum_clr),
        .prods   (prods),
        .run_sum (run_sum)
    );

    assign mag = run_sum[SUM_W-1] ? (~run_sum + SUM_W'(1)) : run_sum;

    slc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mag),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (quot)
    );

    // saturate and take the sign back
    always_comb
    begin
        if (neg_reg)
        begin
            qsat     = (quot > LIM) ? LIM : quot;
            val_bits = VAL_W'(SUM_W'(0) - qsat);
        end
        else
        begin
            qsat     = (quot > LIM - SUM_W'(1)) ? LIM - SUM_W'(1) : quot;
            val_bits = qsat[VAL_W-1:0];
        end
    end

    assign emit_load = (state_reg == S_EMIT) && (!out_valid_reg || out_ready);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        r_next     = r_reg;
        rx_next    = rx_reg;
        ry_next    = ry_reg;
        rz_next    = rz_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        ph_next    = ph_reg;
        drain_next = drain_reg;
        clr_next   = clr_reg;
        sum_clr    = 1'b0;
        div_start  = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (&clr_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (run_go)
                begin
                    state_next = S_WALK;
                    sum_clr    = 1'b1;
                    r_next     = '0;
                    rx_next    = '0;
                    ry_next    = '0;
                    rz_next    = '0;
                    x_next     = '0;
                    y_next     = '0;
                    z_next     = '0;
                    ph_next    = PH_CENTER;
                end
            end
            S_WALK:
            begin
                ph_next = phase_t'(ph_reg + 2'd1);
                if (ph_reg == PH_ZN)
                begin
                    x_next = x_end ? '0 : x_reg + 1'b1;
                    if (x_end)
                    begin
                        y_next = y_end ? '0 : y_reg + 1'b1;
                        if (y_end)
                        begin
                            z_next = z_end ? '0 : z_reg + 1'b1;
                        end
                    end
                    if (x_end && y_end && z_end)
                    begin
                        state_next = S_DRAIN;
                        drain_next = '0;
                    end
                end
            end
            S_DRAIN:
            begin
                drain_next = drain_reg + 1'b1;
                if (drain_reg == DRAIN_LAST)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (emit_load)
                begin
                    if (r_reg == rmax)
                    begin
                        state_next = S_CLEAR;
                        clr_next   = '0;
                    end
                    else
                    begin
                        state_next = S_WALK;
                        sum_clr    = 1'b1;
                        r_next     = r_reg + 1'b1;
                        rx_next    = step_off(rx_reg, lx);
                        ry_next    = step_off(ry_reg, ly);
                        rz_next    = step_off(rz_reg, lz);
                        x_next     = '0;
                        y_next     = '0;
                        z_next     = '0;
                        ph_next    = PH_CENTER;
                    end
                end
            end
            default:
            begin
                state_next = S_CLEAR;
                clr_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            r_reg         <= '0;
            rx_reg        <= '0;
            ry_reg        <= '0;
            rz_reg        <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            z_reg         <= '0;
            ph_reg        <= PH_CENTER;
            drain_reg     <= '0;
            ld_busy_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            r_reg       <= r_next;
            rx_reg      <= rx_next;
            ry_reg      <= ry_next;
            rz_reg      <= rz_next;
            x_reg       <= x_next;
            y_reg       <= y_next;
            z_reg       <= z_next;
            ph_reg      <= ph_next;
            drain_reg   <= drain_next;
            ld_busy_reg <= in_acc && !mode;
            if (emit_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            neg_reg <= run_sum[SUM_W-1];
        end
        if (emit_load)
        begin
            dist_reg  <= r_reg;
            value_reg <= val_bits;
            last_reg  <= (r_reg == rmax);
        end
    end

    assign out_valid = out_valid_reg;
    assign distance  = dist_reg;
    assign value     = $signed(value_reg);
    assign last      = last_reg;

endmodule

// ===== hw/rtl/slc_checker.sv =====
// Port-level checker for the static link correlator, bound to the top level.
`include "assert_macros.svh"

module slc_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              cfg_we,
    input logic [slc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input logic [slc_pkg::CFG_W-1:0]         cfg_data,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              mode,
    input logic [slc_pkg::EXT_W-1:0]         pos_x,
    input logic [slc_pkg::EXT_W-1:0]         pos_y,
    input logic [slc_pkg::EXT_W-1:0]         pos_z,
    input logic [slc_pkg::DIR_W-1:0]         direction,
    input logic signed [slc_pkg::COMP_W-1:0] comp_one,
    input logic signed [slc_pkg::COMP_W-1:0] comp_two,
    input logic signed [slc_pkg::COMP_W-1:0] comp_three,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [slc_pkg::DIST_W-1:0]        distance,
    input logic signed [slc_pkg::VAL_W-1:0]  value,
    input logic                              last
);

    // stalled result holds
    `SLC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    `SLC_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(value) && $stable(distance) && $stable(last))

    // a compute run and a load write-back both block the next transfer
    `SLC_ASSERT_NEXT(a_run_busy, in_valid && in_ready && mode, !in_ready)
    `SLC_ASSERT_NEXT(a_load_gap, in_valid && in_ready && !mode, !in_ready)

    // no new item while a run still has results to come
    `SLC_ASSERT_SAME(a_no_accept_mid_run, out_valid && !last, !in_ready)

endmodule

bind static_link_correlator slc_checker u_slc_checker (.*);
